// File: hdl/nearest_point_ahead_search_core_assert.svh
// assertion macros shared by the search core
// both expect clk and rst_n in scope
`ifndef NEAREST_POINT_AHEAD_SEARCH_CORE_ASSERT_SVH
`define NEAREST_POINT_AHEAD_SEARCH_CORE_ASSERT_SVH

// same-cycle implication
`define NPA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npa: same-cycle check failed");

// next-cycle implication
`define NPA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npa: next-cycle check failed");

`endif

// File: hdl/npa_pkg.sv
`default_nettype none

package npa_pkg;

    localparam int COORD_W  = 20;
    localparam int POINT_W  = 2 * COORD_W;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int PSUM_W   = PROD_W + 1;
    // squared distances and positive dot products stay below 2^41
    localparam int DIST_W   = 2 * COORD_W + 1;
    localparam int INDEX_W  = 10;
    localparam int COS_W    = 16;
    localparam int CMD_W    = 2;

    localparam int MAX_POINTS_DEF = 1024;
    localparam logic [COS_W-1:0] COS_RESET = 16'd498;

    // serial multiplier operand widths
    localparam int MUL_A_W   = DIST_W + COS_W;
    localparam int MUL_B_W   = DIST_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int DOT_SQ_W  = 2 * DIST_W;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [PSUM_W-1:0]  psum_t;
    typedef logic [DIST_W-1:0]         dist_t;

endpackage

`default_nettype wire

// File: hdl/npa_ram.sv
`default_nettype none

module npa_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/npa_psum.sv
`default_nettype none

// three-stage u1*v1 + u2*v2 unit, shared by the distance scan and the angle test
module npa_psum #(
    parameter int TAG_W = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [TAG_W-1:0]      in_tag,
    input  wire npa_pkg::diff_t        u1,
    input  wire npa_pkg::diff_t        v1,
    input  wire npa_pkg::diff_t        u2,
    input  wire npa_pkg::diff_t        v2,
    output logic                       out_valid,
    output logic [TAG_W-1:0]           out_tag,
    output npa_pkg::psum_t             out_sum
);

    logic               s0_valid_reg;
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic [TAG_W-1:0]   s0_tag_reg;
    logic [TAG_W-1:0]   s1_tag_reg;
    logic [TAG_W-1:0]   s2_tag_reg;
    npa_pkg::diff_t     u1_reg;
    npa_pkg::diff_t     v1_reg;
    npa_pkg::diff_t     u2_reg;
    npa_pkg::diff_t     v2_reg;
    npa_pkg::prod_t     p1_reg;
    npa_pkg::prod_t     p2_reg;
    npa_pkg::prod_t     p1_next;
    npa_pkg::prod_t     p2_next;
    npa_pkg::psum_t     sum_reg;
    npa_pkg::psum_t     sum_next;

    assign p1_next  = npa_pkg::PROD_W'(u1_reg) * npa_pkg::PROD_W'(v1_reg);
    assign p2_next  = npa_pkg::PROD_W'(u2_reg) * npa_pkg::PROD_W'(v2_reg);
    assign sum_next = npa_pkg::PSUM_W'(p1_reg) + npa_pkg::PSUM_W'(p2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_tag_reg <= in_tag;
        u1_reg     <= u1;
        v1_reg     <= v1;
        u2_reg     <= u2;
        v2_reg     <= v2;
        s1_tag_reg <= s0_tag_reg;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        s2_tag_reg <= s1_tag_reg;
        sum_reg    <= sum_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_tag   = s2_tag_reg;
    assign out_sum   = sum_reg;

endmodule

`default_nettype wire

// File: hdl/npa_mul.sv
`default_nettype none

// unsigned shift-add multiplier, one bit of b per cycle
module npa_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [npa_pkg::MUL_A_W-1:0] a,
    input  wire logic [npa_pkg::MUL_B_W-1:0] b,
    output logic                             done,
    output logic      [npa_pkg::MUL_P_W-1:0] product
);

    localparam int AW    = npa_pkg::MUL_A_W;
    localparam int BW    = npa_pkg::MUL_B_W;
    localparam int PW    = npa_pkg::MUL_P_W;
    localparam int CNT_W = $clog2(BW + 1);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [AW-1:0]    a_reg;
    logic [PW-1:0]    prod_reg;
    logic [AW:0]      acc_sum;
    logic [PW-1:0]    prod_next;

    assign acc_sum   = {1'b0, prod_reg[PW-1:BW]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
    assign prod_next = {acc_sum, prod_reg[BW-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(BW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            prod_reg <= {AW'(0), b};
        end
        else if (run_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

// File: hdl/nearest_point_ahead_search_core.sv
`default_nettype none

// Path store with a nearest-point-ahead query. Clear and append leave busy
// low. A query with two or more stored points raises busy while the stored
// points are scanned one per cycle through the single memory read port, the
// scan pipeline drains and the two vector sums run, and then while the angle
// test runs three 57x41-bit products on a serial multiplier, each as a start
// step, 41 shift-add steps and a done step. A nearest point that is the
// last one ends the query after the scan; a zero vector or a dot product at
// or below zero ends it after the two vector sums. With zero or one point the
// result comes the cycle after the transfer with busy staying low. The result
// shows on ahead_index for one cycle with done high; the receiver cannot
// stall it and must take it then.
module nearest_point_ahead_search_core #(
    parameter int MAX_POINTS = npa_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [npa_pkg::CMD_W-1:0]     command,
    input  wire npa_pkg::coord_t               x_pos,
    input  wire npa_pkg::coord_t               y_pos,
    input  wire logic                          cfg_wr_en,
    input  wire logic [npa_pkg::COS_W-1:0]     cfg_wr_data,
    output logic                               done,
    output logic      [npa_pkg::INDEX_W-1:0]   ahead_index
);

    `include "nearest_point_ahead_search_core_assert.svh"

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = (AW > npa_pkg::INDEX_W) ? AW : npa_pkg::INDEX_W;
    localparam int CO = npa_pkg::COORD_W;
    localparam int PW = npa_pkg::POINT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_CHECK,
        ST_RD_NEXT,
        ST_LD_NEXT,
        ST_ISSUE_DOT,
        ST_WAIT_MB,
        ST_WAIT_DOT,
        ST_M1_GO,
        ST_M1_RUN,
        ST_M2_GO,
        ST_M2_RUN,
        ST_M3_GO,
        ST_M3_RUN
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic                             done_reg;
    logic                             done_next;
    logic [npa_pkg::INDEX_W-1:0]      index_reg;
    logic [npa_pkg::INDEX_W-1:0]      index_next;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic [AW-1:0]                    scan_idx_reg;
    logic [AW-1:0]                    scan_idx_next;
    logic                             rd_scan_reg;
    logic                             rd_scan_next;
    logic [npa_pkg::COS_W-1:0]        cos_reg;

    logic [AW-1:0]                    rd_tag_reg;
    npa_pkg::coord_t                  qx_reg;
    npa_pkg::coord_t                  qy_reg;
    npa_pkg::dist_t                   best_reg;
    logic [AW-1:0]                    near_reg;
    npa_pkg::coord_t                  near_x_reg;
    npa_pkg::coord_t                  near_y_reg;
    npa_pkg::diff_t                   bx_reg;
    npa_pkg::diff_t                   by_reg;
    npa_pkg::dist_t                   magb_reg;
    npa_pkg::dist_t                   dot_reg;
    logic [npa_pkg::MUL_P_W-1:0]      lhs_reg;
    logic [npa_pkg::MUL_A_W-1:0]      m2_reg;

    logic                             accept;
    logic [CW-1:0]                    last_idx;
    logic [AW-1:0]                    next_idx;
    logic                             ram_we;
    logic                             ram_rd_en;
    logic [AW-1:0]                    ram_rd_addr;
    logic [PW-1:0]                    ram_rd_data;
    npa_pkg::coord_t                  rd_x;
    npa_pkg::coord_t                  rd_y;

    logic                             psum_in_valid;
    npa_pkg::diff_t                   psum_u1;
    npa_pkg::diff_t                   psum_v1;
    npa_pkg::diff_t                   psum_u2;
    npa_pkg::diff_t                   psum_v2;
    logic                             psum_out_valid;
    logic [AW-1:0]                    psum_out_tag;
    npa_pkg::psum_t                   psum_out_sum;
    npa_pkg::dist_t                   psum_dist;
    npa_pkg::diff_t                   scan_dx;
    npa_pkg::diff_t                   scan_dy;

    logic                             mul_start;
    logic [npa_pkg::MUL_A_W-1:0]      mul_a;
    logic [npa_pkg::MUL_B_W-1:0]      mul_b;
    logic                             mul_done;
    logic [npa_pkg::MUL_P_W-1:0]      mul_product;

    function automatic logic [npa_pkg::INDEX_W-1:0] to_index(input logic [AW-1:0] idx);
        logic [IW-1:0] wide;
        wide = IW'(idx);
        return wide[npa_pkg::INDEX_W-1:0];
    endfunction

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign last_idx = count_reg - CW'(1);
    assign next_idx = near_reg + AW'(1);
    assign ram_we   = accept && (command == npa_pkg::CMD_APPEND)
                      && (count_reg < CW'(MAX_POINTS));
    assign rd_x     = ram_rd_data[CO-1:0];
    assign rd_y     = ram_rd_data[PW-1:CO];
    assign scan_dx  = npa_pkg::DIFF_W'(qx_reg) - npa_pkg::DIFF_W'(rd_x);
    assign scan_dy  = npa_pkg::DIFF_W'(qy_reg) - npa_pkg::DIFF_W'(rd_y);
    assign psum_dist = psum_out_sum[npa_pkg::DIST_W-1:0];

    npa_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_point_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({y_pos, x_pos}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    npa_psum #(
        .TAG_W (AW)
    ) u_psum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (psum_in_valid),
        .in_tag    (rd_tag_reg),
        .u1        (psum_u1),
        .v1        (psum_v1),
        .u2        (psum_u2),
        .v2        (psum_v2),
        .out_valid (psum_out_valid),
        .out_tag   (psum_out_tag),
        .out_sum   (psum_out_sum)
    );

    npa_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        index_next    = index_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        rd_scan_next  = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = scan_idx_reg;
        psum_in_valid = rd_scan_reg;
        psum_u1       = scan_dx;
        psum_v1       = scan_dx;
        psum_u2       = scan_dy;
        psum_v2       = scan_dy;
        mul_start     = 1'b0;
        mul_a         = npa_pkg::MUL_A_W'(dot_reg);
        mul_b         = dot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        npa_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        npa_pkg::CMD_APPEND:
                        begin
                            if (count_reg < CW'(MAX_POINTS))
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        npa_pkg::CMD_QUERY:
                        begin
                            if (count_reg <= CW'(1))
                            begin
                                done_next  = 1'b1;
                                index_next = '0;
                            end
                            else
                            begin
                                scan_idx_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                ram_rd_en    = 1'b1;
                rd_scan_next = 1'b1;
                if (CW'(scan_idx_reg) == last_idx)
                begin
                    state_next = ST_SCAN_WAIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
            end
            ST_SCAN_WAIT:
            begin
                if (psum_out_valid && (CW'(psum_out_tag) == last_idx))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (CW'(near_reg) == last_idx)
                begin
                    done_next  = 1'b1;
                    index_next = to_index(near_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = near_reg;
                    state_next  = ST_RD_NEXT;
                end
            end
            ST_RD_NEXT:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = next_idx;
                state_next  = ST_LD_NEXT;
            end
            ST_LD_NEXT:
            begin
                // |b|^2 from next point minus nearest point
                psum_in_valid = 1'b1;
                psum_u1       = npa_pkg::DIFF_W'(rd_x) - npa_pkg::DIFF_W'(near_x_reg);
                psum_v1       = psum_u1;
                psum_u2       = npa_pkg::DIFF_W'(rd_y) - npa_pkg::DIFF_W'(near_y_reg);
                psum_v2       = psum_u2;
                state_next    = ST_ISSUE_DOT;
            end
            ST_ISSUE_DOT:
            begin
                psum_in_valid = 1'b1;
                psum_u1       = npa_pkg::DIFF_W'(qx_reg) - npa_pkg::DIFF_W'(near_x_reg);
                psum_v1       = bx_reg;
                psum_u2       = npa_pkg::DIFF_W'(qy_reg) - npa_pkg::DIFF_W'(near_y_reg);
                psum_v2       = by_reg;
                state_next    = ST_WAIT_MB;
            end
            ST_WAIT_MB:
            begin
                if (psum_out_valid)
                begin
                    state_next = ST_WAIT_DOT;
                end
            end
            ST_WAIT_DOT:
            begin
                if (psum_out_valid)
                begin
                    priority if ((best_reg == '0) || (magb_reg == '0))
                    begin
                        done_next  = 1'b1;
                        index_next = to_index(next_idx);
                        state_next = ST_IDLE;
                    end
                    else if (psum_out_sum[npa_pkg::PSUM_W-1] || (psum_out_sum == '0))
                    begin
                        done_next  = 1'b1;
                        index_next = to_index(near_reg);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_M1_GO;
                    end
                end
            end
            ST_M1_GO:
            begin
                mul_start  = 1'b1;
                state_next = ST_M1_RUN;
            end
            ST_M1_RUN:
            begin
                if (mul_done)
                begin
                    state_next = ST_M2_GO;
                end
            end
            ST_M2_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = npa_pkg::MUL_A_W'(best_reg);
                mul_b      = npa_pkg::MUL_B_W'(cos_reg);
                state_next = ST_M2_RUN;
            end
            ST_M2_RUN:
            begin
                if (mul_done)
                begin
                    state_next = ST_M3_GO;
                end
            end
            ST_M3_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = m2_reg;
                mul_b      = magb_reg;
                state_next = ST_M3_RUN;
            end
            ST_M3_RUN:
            begin
                if (mul_done)
                begin
                    // in front when dot^2 * 2^16 < limit * |a|^2 * |b|^2
                    done_next  = 1'b1;
                    index_next = (lhs_reg < mul_product) ? to_index(near_reg)
                                                         : to_index(next_idx);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            index_reg    <= '0;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rd_scan_reg  <= 1'b0;
            cos_reg      <= npa_pkg::COS_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            index_reg    <= index_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            rd_scan_reg  <= rd_scan_next;
            if (cfg_wr_en)
            begin
                cos_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg <= x_pos;
            qy_reg <= y_pos;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_tag_reg <= scan_idx_reg;
        end
        // lowest index wins a tie: only a strictly smaller distance replaces
        if (psum_out_valid && ((state_reg == ST_SCAN) || (state_reg == ST_SCAN_WAIT))
            && ((psum_out_tag == '0) || (psum_dist < best_reg)))
        begin
            best_reg <= psum_dist;
            near_reg <= psum_out_tag;
        end
        if (state_reg == ST_RD_NEXT)
        begin
            near_x_reg <= rd_x;
            near_y_reg <= rd_y;
        end
        if (state_reg == ST_LD_NEXT)
        begin
            bx_reg <= psum_u1;
            by_reg <= psum_u2;
        end
        if (psum_out_valid && (state_reg == ST_WAIT_MB))
        begin
            magb_reg <= psum_dist;
        end
        if (psum_out_valid && (state_reg == ST_WAIT_DOT))
        begin
            dot_reg <= psum_dist;
        end
        if (mul_done && (state_reg == ST_M1_RUN))
        begin
            lhs_reg <= {mul_product[npa_pkg::DOT_SQ_W-1:0], npa_pkg::COS_W'(0)};
        end
        if (mul_done && (state_reg == ST_M2_RUN))
        begin
            m2_reg <= mul_product[npa_pkg::MUL_A_W-1:0];
        end
    end

    assign done        = done_reg;
    assign ahead_index = index_reg;

    `NPA_ASSERT_IMP(a_done_when_idle, done_reg, state_reg == ST_IDLE)
    `NPA_ASSERT_IMP(a_count_bounded, 1'b1, count_reg <= CW'(MAX_POINTS))
    `NPA_ASSERT_IMP(a_psum_expected, psum_out_valid,
        state_reg == ST_SCAN || state_reg == ST_SCAN_WAIT
        || state_reg == ST_WAIT_MB || state_reg == ST_WAIT_DOT)
    `NPA_ASSERT_IMP(a_mul_expected, mul_done,
        state_reg == ST_M1_RUN || state_reg == ST_M2_RUN || state_reg == ST_M3_RUN)
    `NPA_ASSERT_NEXT(a_query_goes_busy,
        accept && command == npa_pkg::CMD_QUERY && count_reg > CW'(1), busy && !done_reg)

endmodule

`default_nettype wire

// File: verif/tb_nearest_point_ahead_search_core.sv
`timescale 1ns / 1ps

module tb_nearest_point_ahead_search_core;

    localparam logic [npa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PATH_DEPTH    = npa_pkg::MAX_POINTS_DEF;
    localparam int COORD_HI      = 524287;
    localparam int COORD_LO      = -524288;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 1300;

    typedef struct packed {
        logic [npa_pkg::CMD_W-1:0] cmd;
        npa_pkg::coord_t           x;
        npa_pkg::coord_t           y;
    } path_cmd_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          start       = 1'b0;
    logic [npa_pkg::CMD_W-1:0]     command     = npa_pkg::CMD_CLEAR;
    npa_pkg::coord_t               x_pos       = '0;
    npa_pkg::coord_t               y_pos       = '0;
    logic                          cfg_wr_en   = 1'b0;
    logic [npa_pkg::COS_W-1:0]     cfg_wr_data = '0;
    logic                          busy;
    logic                          done;
    logic [npa_pkg::INDEX_W-1:0]   ahead_index;

    // stimulus side
    path_cmd_t                     cmd_q[$];
    path_cmd_t                     cur_cmd;
    int                            n_sent   = 0;
    int                            gap_left = 0;
    bit                            idle_en  = 1'b1;
    int                            gen_x[PATH_DEPTH];
    int                            gen_y[PATH_DEPTH];
    int                            gen_len  = 0;

    // predictor side
    npa_pkg::coord_t               trk_x[PATH_DEPTH];
    npa_pkg::coord_t               trk_y[PATH_DEPTH];
    int                            trk_len  = 0;
    logic [npa_pkg::COS_W-1:0]     trk_cos  = npa_pkg::COS_RESET;
    logic [npa_pkg::INDEX_W-1:0]   ahead_q[$];
    logic [npa_pkg::INDEX_W-1:0]   exp_idx;
    logic [npa_pkg::INDEX_W-1:0]   pred_idx;
    int                            n_taken  = 0;
    int                            n_fail   = 0;

    nearest_point_ahead_search_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .ahead_index (ahead_index)
    );

    always #1 clk = ~clk;

    function automatic logic [npa_pkg::INDEX_W-1:0] nearest_ahead(
        input npa_pkg::coord_t qx,
        input npa_pkg::coord_t qy
    );
        longint dx, dy, d, best, ax, ay, bx, by, mag_a, mag_b, dotp;
        int near_i;
        logic [127:0] lhs, rhs;
        near_i = 0;
        best = 0;
        if (trk_len <= 1)
            return '0;
        for (int i = 0; i < trk_len; i++)
        begin
            dx = longint'(qx) - longint'(trk_x[i]);
            dy = longint'(qy) - longint'(trk_y[i]);
            d = dx * dx + dy * dy;
            // strict compare keeps the lowest index on a tie
            if (i == 0 || d < best)
            begin
                best = d;
                near_i = i;
            end
        end
        if (near_i == trk_len - 1)
            return npa_pkg::INDEX_W'(near_i);
        ax = longint'(qx) - longint'(trk_x[near_i]);
        ay = longint'(qy) - longint'(trk_y[near_i]);
        bx = longint'(trk_x[near_i + 1]) - longint'(trk_x[near_i]);
        by = longint'(trk_y[near_i + 1]) - longint'(trk_y[near_i]);
        mag_a = ax * ax + ay * ay;
        mag_b = bx * bx + by * by;
        if (mag_a == 0 || mag_b == 0)
            return npa_pkg::INDEX_W'(near_i + 1);
        dotp = ax * bx + ay * by;
        if (dotp <= 0)
            return npa_pkg::INDEX_W'(near_i);
        lhs = (128'(dotp) * 128'(dotp)) << 16;
        rhs = 128'(mag_a) * 128'(trk_cos) * 128'(mag_b);
        if (lhs < rhs)
            return npa_pkg::INDEX_W'(near_i);
        return npa_pkg::INDEX_W'(near_i + 1);
    endfunction

    // predictor and result check, both on the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            trk_len = 0;
            trk_cos = npa_pkg::COS_RESET;
        end
        else
        begin
            if (done)
            begin
                if (ahead_q.size() == 0)
                begin
                    $error("ahead_index: expected none, actual %0d", ahead_index);
                    n_fail++;
                end
                else
                begin
                    exp_idx = ahead_q.pop_front();
                    if (ahead_index !== exp_idx)
                    begin
                        $error("ahead_index: expected %0d, actual %0d", exp_idx, ahead_index);
                        n_fail++;
                    end
                end
            end
            if (cfg_wr_en)
                trk_cos = cfg_wr_data;
            if (start && !busy)
            begin
                n_taken++;
                case (command)
                    npa_pkg::CMD_CLEAR:
                        trk_len = 0;
                    npa_pkg::CMD_APPEND:
                        // full store drops the point
                        if (trk_len < PATH_DEPTH)
                        begin
                            trk_x[trk_len] = x_pos;
                            trk_y[trk_len] = y_pos;
                            trk_len++;
                        end
                    npa_pkg::CMD_QUERY:
                    begin
                        pred_idx = nearest_ahead(x_pos, y_pos);
                        ahead_q = {ahead_q, pred_idx};
                    end
                    default:
                        ;
                endcase
            end
        end
    end

    // command driver, changes on the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!start || n_taken == n_sent))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(0, 16);
                start <= 1'b0;
            end
            else if (cmd_q.size() != 0)
            begin
                cur_cmd = cmd_q.pop_front();
                start   <= 1'b1;
                command <= cur_cmd.cmd;
                x_pos   <= cur_cmd.x;
                y_pos   <= cur_cmd.y;
                n_sent++;
            end
            else
                start <= 1'b0;
        end
    end

    function automatic int sat_coord(input int v);
        if (v > COORD_HI)
            return COORD_HI;
        if (v < COORD_LO)
            return COORD_LO;
        return v;
    endfunction

    task automatic push_item(
        input logic [npa_pkg::CMD_W-1:0] c,
        input npa_pkg::coord_t           xv,
        input npa_pkg::coord_t           yv
    );
        path_cmd_t pc;
        pc.cmd = c;
        pc.x = xv;
        pc.y = yv;
        cmd_q = {cmd_q, pc};
    endtask

    // random walk of appends; roughly one step in twelve repeats the last point
    task automatic append_walk(input int len, input int scale);
        int cx, cy;
        cx = 0;
        cy = 0;
        if (gen_len != 0)
        begin
            cx = gen_x[gen_len - 1];
            cy = gen_y[gen_len - 1];
        end
        for (int k = 0; k < len; k++)
        begin
            if (gen_len == 0 && k == 0)
            begin
                cx = int'(npa_pkg::coord_t'($urandom));
                cy = int'(npa_pkg::coord_t'($urandom));
            end
            else if ($urandom_range(0, 11) != 0)
            begin
                cx = sat_coord(cx + int'($urandom_range(0, 2 * scale)) - scale);
                cy = sat_coord(cy + int'($urandom_range(0, 2 * scale)) - scale);
            end
            push_item(npa_pkg::CMD_APPEND, npa_pkg::coord_t'(cx), npa_pkg::coord_t'(cy));
            if (gen_len < PATH_DEPTH)
            begin
                gen_x[gen_len] = cx;
                gen_y[gen_len] = cy;
                gen_len++;
            end
        end
    endtask

    // query on a path point, near one, or anywhere
    task automatic push_query(input int scale);
        int k, m, qx, qy;
        m = $urandom_range(0, 9);
        if (gen_len == 0 || m == 0)
            push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'($urandom),
                      npa_pkg::coord_t'($urandom));
        else
        begin
            k = $urandom_range(0, gen_len - 1);
            qx = gen_x[k];
            qy = gen_y[k];
            if (m > 2)
            begin
                qx = sat_coord(qx + int'($urandom_range(0, 4 * scale)) - 2 * scale);
                qy = sat_coord(qy + int'($urandom_range(0, 4 * scale)) - 2 * scale);
            end
            push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(qx), npa_pkg::coord_t'(qy));
        end
    endtask

    task automatic run_random(input int n);
        int made, len, scale, nq;
        logic [npa_pkg::CMD_W-1:0] c;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                scale = 1 << $urandom_range(1, 14);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
                nq = $urandom_range(1, 6);
                push_item(npa_pkg::CMD_CLEAR, npa_pkg::coord_t'($urandom),
                          npa_pkg::coord_t'($urandom));
                gen_len = 0;
                append_walk(len, scale);
                repeat (nq) push_query(scale);
                made += 1 + len + nq;
            end
            else
            begin
                c = npa_pkg::CMD_W'($urandom_range(0, 3));
                push_item(c, npa_pkg::coord_t'($urandom), npa_pkg::coord_t'($urandom));
                if (c != CMD_UNUSED)
                    made++;
            end
        end
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || n_taken != n_sent || ahead_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_cos(input logic [npa_pkg::COS_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset value of the cos limit
        push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(0), npa_pkg::coord_t'(0));
        push_item(npa_pkg::CMD_APPEND, npa_pkg::coord_t'(COORD_HI), npa_pkg::coord_t'(COORD_HI));
        push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(COORD_LO), npa_pkg::coord_t'(COORD_LO));
        push_item(npa_pkg::CMD_CLEAR, npa_pkg::coord_t'(COORD_LO), npa_pkg::coord_t'(COORD_HI));
        push_item(npa_pkg::CMD_APPEND, npa_pkg::coord_t'(0), npa_pkg::coord_t'(0));
        push_item(npa_pkg::CMD_APPEND, npa_pkg::coord_t'(1000), npa_pkg::coord_t'(0));
        push_item(npa_pkg::CMD_APPEND, npa_pkg::coord_t'(2000), npa_pkg::coord_t'(0));
        push_item(npa_pkg::CMD_APPEND, npa_pkg::coord_t'(2000), npa_pkg::coord_t'(0));
        push_item(npa_pkg::CMD_APPEND, npa_pkg::coord_t'(COORD_LO), npa_pkg::coord_t'(COORD_HI));
        push_item(npa_pkg::CMD_APPEND, npa_pkg::coord_t'(COORD_HI), npa_pkg::coord_t'(COORD_LO));
        push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(-100), npa_pkg::coord_t'(50));
        push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(100), npa_pkg::coord_t'(5));
        push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(10), npa_pkg::coord_t'(500));
        push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(1000), npa_pkg::coord_t'(0));
        push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(2005), npa_pkg::coord_t'(1));
        push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(500), npa_pkg::coord_t'(0));
        push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(-524000), npa_pkg::coord_t'(COORD_HI));
        push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(COORD_HI), npa_pkg::coord_t'(COORD_LO));
        push_item(CMD_UNUSED, npa_pkg::coord_t'(-1), npa_pkg::coord_t'(-1));
        push_item(npa_pkg::CMD_QUERY, npa_pkg::coord_t'(COORD_LO), npa_pkg::coord_t'(COORD_LO));
        drain();

        set_cos('0);
        run_random(140);
        drain();

        set_cos('1);
        run_random(140);
        drain();

        set_cos(npa_pkg::COS_W'($urandom));
        run_random(130);
        drain();

        // one walk of 24 appends on the reset limit
        set_cos(npa_pkg::COS_RESET);
        push_item(npa_pkg::CMD_CLEAR, npa_pkg::coord_t'(0), npa_pkg::coord_t'(0));
        gen_len = 0;
        append_walk(24, 400);
        repeat (6) push_query(400);
        drain();

        // last part runs back to back
        set_cos(npa_pkg::COS_W'($urandom_range(1, 8000)));
        idle_en = 1'b0;
        run_random(110);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_fail == 0)
            $display("[nearest_point_ahead_search_core] OK");
        else
            $display("[nearest_point_ahead_search_core] ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[nearest_point_ahead_search_core] ERROR");
        $finish;
    end

endmodule
